// ===== rtl/core/frzc_pkg.sv =====
package frzc_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int MAG_W      = 16;
   localparam int RMS_W      = 16;
   localparam int ZCR_W      = 17;
   localparam int CREST_W    = 16;
   localparam int PEAK_W     = 16;
   localparam int FRAME_W    = 13;
   localparam int ZCR_FRAC   = 16;
   localparam int CREST_FRAC = 8;
   localparam int SQ_W       = 30;

   // integer square root working width and first trial bit position
   localparam int ROOT_W   = 32;
   localparam int ROOT_TOP = 30;

   localparam logic [CREST_W-1:0] CREST_MAX = '1;

   typedef struct packed {
      logic [RMS_W-1:0]   rms_level;
      logic [ZCR_W-1:0]   zero_cross_rate;
      logic [CREST_W-1:0] crest_factor;
      logic [PEAK_W-1:0]  peak_magnitude;
      logic [FRAME_W-1:0] frame_samples;
   } result_type;

endpackage

// ===== rtl/core/frzc_front.sv =====
module frzc_front #(
   parameter int MAX_FRAME = 4096,
   parameter int CNT_W     = 13,
   parameter int CROSS_W   = 12,
   parameter int SUM_W     = 43
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [frzc_pkg::SAMPLE_W-1:0] sample,
   input  logic                               last_sample,
   input  logic                               q_full,
   output logic                               q_push,
   output logic [SUM_W-1:0]                   push_sum,
   output logic [CNT_W-1:0]                   push_count,
   output logic [CROSS_W-1:0]                 push_cross,
   output logic [frzc_pkg::PEAK_W-1:0]        push_peak
);

   logic [SUM_W-1:0]                  sum_ff, sum_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [CROSS_W-1:0]                cross_ff, cross_in;
   logic [frzc_pkg::PEAK_W-1:0]       peak_ff, peak_in;
   logic                              prev_neg_ff;
   logic                              neg;
   logic [frzc_pkg::SAMPLE_W:0]       ext;
   logic [frzc_pkg::MAG_W-1:0]        mag;
   logic [2*frzc_pkg::MAG_W-1:0]      sq;
   logic                              accept;
   logic                              frame_end;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   assign neg = sample[frzc_pkg::SAMPLE_W-1];
   assign ext = {sample[frzc_pkg::SAMPLE_W-1], sample};
   // -32768 maps to 0x8000, which still fits unsigned
   always_comb begin
      if (neg) begin
         mag = frzc_pkg::MAG_W'(-ext);
      end else begin
         mag = frzc_pkg::MAG_W'(ext);
      end
   end

   assign sq       = mag * mag;
   assign sum_in   = sum_ff + SUM_W'(sq);
   assign peak_in  = (mag > peak_ff) ? mag : peak_ff;
   assign count_in = count_ff + CNT_W'(1);
   always_comb begin
      if (count_ff != '0 && neg != prev_neg_ff) begin
         cross_in = cross_ff + CROSS_W'(1);
      end else begin
         cross_in = cross_ff;
      end
   end

   assign frame_end = last_sample || (count_in == CNT_W'(MAX_FRAME));
   assign q_push    = accept && frame_end;

   assign push_sum   = sum_in;
   assign push_count = count_in;
   assign push_cross = cross_in;
   assign push_peak  = peak_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= '0;
         count_ff    <= '0;
         cross_ff    <= '0;
         peak_ff     <= '0;
         prev_neg_ff <= 1'b0;
      end else if (accept) begin
         if (frame_end) begin
            sum_ff      <= '0;
            count_ff    <= '0;
            cross_ff    <= '0;
            peak_ff     <= '0;
            prev_neg_ff <= 1'b0;
         end else begin
            sum_ff      <= sum_in;
            count_ff    <= count_in;
            cross_ff    <= cross_in;
            peak_ff     <= peak_in;
            prev_neg_ff <= neg;
         end
      end
   end

endmodule

// ===== rtl/core/frzc_queue.sv =====
module frzc_queue #(
   parameter int DATA_W = 84
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);

   logic [DATA_W-1:0] mem [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        fill_ff;

   assign full     = (fill_ff == 2'd2);
   assign empty    = (fill_ff == 2'd0);
   assign pop_data = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   fill_ff <= fill_ff + 2'd1;
            2'b01:   fill_ff <= fill_ff - 2'd1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end

endmodule

// ===== rtl/core/frzc_div.sv =====
module frzc_div #(
   parameter int DVD_W = 43,
   parameter int DVS_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int STEP_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

   logic [DVD_W-1:0]  quo_ff;
   logic [DVS_W-1:0]  dvs_ff;
   logic [DVS_W-1:0]  rem_ff;
   logic [STEP_W-1:0] step_ff;
   logic              run_ff;
   logic              done_ff;
   logic [DVS_W:0]    rem_sh;
   logic [DVS_W:0]    diff;
   logic              ge;

   // restoring division, one quotient bit per cycle
   assign rem_sh = {rem_ff, quo_ff[DVD_W-1]};
   assign ge     = (rem_sh >= {1'b0, dvs_ff});
   assign diff   = rem_sh - {1'b0, dvs_ff};

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DVD_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
      end else if (run_ff) begin
         quo_ff <= {quo_ff[DVD_W-2:0], ge};
         rem_ff <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      end
   end

endmodule

// ===== rtl/core/frzc_back.sv =====
module frzc_back #(
   parameter int CNT_W   = 13,
   parameter int CROSS_W = 12,
   parameter int SUM_W   = 43
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   output logic                         q_pop,
   input  logic [SUM_W-1:0]             q_sum,
   input  logic [CNT_W-1:0]             q_count,
   input  logic [CROSS_W-1:0]           q_cross,
   input  logic [frzc_pkg::PEAK_W-1:0]  q_peak,
   output logic                         res_valid,
   input  logic                         res_take,
   output frzc_pkg::result_type         res_data
);

   localparam int ZCR_DVD   = CROSS_W + frzc_pkg::ZCR_FRAC;
   localparam int CREST_DVD = frzc_pkg::PEAK_W + frzc_pkg::CREST_FRAC;
   localparam int DVD_A     = (SUM_W > ZCR_DVD) ? SUM_W : ZCR_DVD;
   localparam int DVD_W     = (DVD_A > CREST_DVD) ? DVD_A : CREST_DVD;
   localparam int DVS_W     = (CNT_W > frzc_pkg::RMS_W) ? CNT_W : frzc_pkg::RMS_W;

   typedef enum logic [2:0] {
      IDLE,
      MEAN,
      ROOT,
      ZCR_GO,
      ZCR_WAIT,
      CREST_GO,
      CREST_WAIT,
      DONE
   } state_type;

   state_type                          state_ff;
   logic [CNT_W-1:0]                   n_ff;
   logic [CROSS_W-1:0]                 cross_ff;
   logic [frzc_pkg::PEAK_W-1:0]        peak_ff;
   logic [frzc_pkg::ROOT_W-1:0]        v_ff;
   logic [frzc_pkg::ROOT_W-1:0]        res_ff;
   logic [frzc_pkg::ROOT_W-1:0]        bit_ff;
   logic [frzc_pkg::ZCR_W-1:0]         zcr_ff;
   logic [frzc_pkg::CREST_W-1:0]       crest_ff;
   logic [frzc_pkg::ROOT_W-1:0]        root_try;
   logic [frzc_pkg::RMS_W-1:0]         rms;
   logic                               short_frame;
   logic                               div_start;
   logic [DVD_W-1:0]                   div_dvd;
   logic [DVS_W-1:0]                   div_dvs;
   logic                               div_done;
   logic [DVD_W-1:0]                   div_quo;

   assign rms         = res_ff[frzc_pkg::RMS_W-1:0];
   assign root_try    = res_ff + bit_ff;
   assign short_frame = (n_ff < CNT_W'(2));
   assign q_pop       = (state_ff == IDLE) && !q_empty;

   always_comb begin
      div_start = 1'b0;
      div_dvd   = DVD_W'(q_sum);
      div_dvs   = DVS_W'(q_count);
      case (state_ff)
         IDLE: begin
            div_start = !q_empty;
         end
         ZCR_GO: begin
            div_start = !short_frame;
            div_dvd   = DVD_W'({cross_ff, {frzc_pkg::ZCR_FRAC{1'b0}}});
            div_dvs   = DVS_W'(n_ff - CNT_W'(1));
         end
         CREST_GO: begin
            div_start = (rms != '0);
            div_dvd   = DVD_W'({peak_ff, {frzc_pkg::CREST_FRAC{1'b0}}});
            div_dvs   = DVS_W'(rms);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   frzc_div #(
      .DVD_W (DVD_W),
      .DVS_W (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         case (state_ff)
            IDLE: begin
               if (!q_empty) begin
                  n_ff     <= q_count;
                  cross_ff <= q_cross;
                  peak_ff  <= q_peak;
                  state_ff <= MEAN;
               end
            end
            MEAN: begin
               if (div_done) begin
                  v_ff     <= frzc_pkg::ROOT_W'(div_quo);
                  res_ff   <= '0;
                  bit_ff   <= frzc_pkg::ROOT_W'(1) << frzc_pkg::ROOT_TOP;
                  state_ff <= ROOT;
               end
            end
            ROOT: begin
               // one result bit per cycle, trial bit walks down by powers of four
               if (v_ff >= root_try) begin
                  v_ff   <= v_ff - root_try;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if (bit_ff == frzc_pkg::ROOT_W'(1)) begin
                  state_ff <= ZCR_GO;
               end
            end
            ZCR_GO: begin
               if (short_frame) begin
                  zcr_ff   <= '0;
                  state_ff <= CREST_GO;
               end else begin
                  state_ff <= ZCR_WAIT;
               end
            end
            ZCR_WAIT: begin
               if (div_done) begin
                  zcr_ff   <= div_quo[frzc_pkg::ZCR_W-1:0];
                  state_ff <= CREST_GO;
               end
            end
            CREST_GO: begin
               if (rms == '0) begin
                  crest_ff <= '0;
                  state_ff <= DONE;
               end else begin
                  state_ff <= CREST_WAIT;
               end
            end
            CREST_WAIT: begin
               if (div_done) begin
                  if (|div_quo[DVD_W-1:frzc_pkg::CREST_W]) begin
                     crest_ff <= frzc_pkg::CREST_MAX;
                  end else begin
                     crest_ff <= div_quo[frzc_pkg::CREST_W-1:0];
                  end
                  state_ff <= DONE;
               end
            end
            DONE: begin
               if (res_take) begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign res_valid = (state_ff == DONE);

   always_comb begin
      res_data.rms_level       = rms;
      res_data.zero_cross_rate = zcr_ff;
      res_data.crest_factor    = crest_ff;
      res_data.peak_magnitude  = peak_ff;
      res_data.frame_samples   = frzc_pkg::FRAME_W'(n_ff);
   end

endmodule

// ===== rtl/core/frame_rms_zcr_crest_top.sv =====
// per-frame rms level, zero-crossing rate and crest factor of a q1.15 audio stream
// request channel: req_valid / req_stall carry one sample and its last_sample flag;
//   a frame also closes by itself on its MAX_FRAME-th sample
// response channel: rsp_valid / rsp_stall carry one result per frame, taken from
//   an output register
// samples are taken one per cycle while req_stall is low; a front accumulator folds
//   each sample in as it arrives and at frame end hands the totals to a two-entry queue
// the back end works on one frame at a time with a shared bit-serial divider:
//   mean-square divide, integer square root, zero-crossing divide (skipped for
//   one-sample frames), crest divide (skipped when rms is 0), plus sequencing states
// while the back end works on a frame, the front can keep taking samples of later frames
// req_stall rises only while the queue holds two finished frames
// when the receiver stalls, the response register holds its result, the back end
//   finishes the next frame and waits, and sample intake continues until the queue fills
// synchronous reset clears the accumulators, empties the queue and drops rsp_valid
module frame_rms_zcr_crest_top #(
   parameter int MAX_FRAME = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [frzc_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                  req_last_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [frzc_pkg::RMS_W-1:0]            rsp_rms_level,
   output logic [frzc_pkg::ZCR_W-1:0]            rsp_zero_cross_rate,
   output logic [frzc_pkg::CREST_W-1:0]          rsp_crest_factor,
   output logic [frzc_pkg::PEAK_W-1:0]           rsp_peak_magnitude,
   output logic [frzc_pkg::FRAME_W-1:0]          rsp_frame_samples
);

   localparam int CNT_W   = $clog2(MAX_FRAME + 1);
   localparam int CROSS_W = $clog2(MAX_FRAME);
   localparam int SUM_W   = frzc_pkg::SQ_W + CNT_W;
   localparam int REC_W   = SUM_W + CNT_W + CROSS_W + frzc_pkg::PEAK_W;

   logic                          q_full;
   logic                          q_empty;
   logic                          q_push;
   logic                          q_pop;
   logic [SUM_W-1:0]              push_sum;
   logic [CNT_W-1:0]              push_count;
   logic [CROSS_W-1:0]            push_cross;
   logic [frzc_pkg::PEAK_W-1:0]   push_peak;
   logic [REC_W-1:0]              push_rec;
   logic [REC_W-1:0]              pop_rec;
   logic [SUM_W-1:0]              pop_sum;
   logic [CNT_W-1:0]              pop_count;
   logic [CROSS_W-1:0]            pop_cross;
   logic [frzc_pkg::PEAK_W-1:0]   pop_peak;
   logic                          res_valid;
   logic                          res_take;
   frzc_pkg::result_type          res_data;
   logic                          rsp_valid_ff;
   frzc_pkg::result_type          rsp_data_ff;

   frzc_front #(
      .MAX_FRAME (MAX_FRAME),
      .CNT_W     (CNT_W),
      .CROSS_W   (CROSS_W),
      .SUM_W     (SUM_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .sample      (req_sample),
      .last_sample (req_last_sample),
      .q_full      (q_full),
      .q_push      (q_push),
      .push_sum    (push_sum),
      .push_count  (push_count),
      .push_cross  (push_cross),
      .push_peak   (push_peak)
   );

   assign push_rec = {push_sum, push_count, push_cross, push_peak};

   frzc_queue #(
      .DATA_W (REC_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_rec),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_rec),
      .empty     (q_empty)
   );

   assign {pop_sum, pop_count, pop_cross, pop_peak} = pop_rec;

   frzc_back #(
      .CNT_W   (CNT_W),
      .CROSS_W (CROSS_W),
      .SUM_W   (SUM_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_sum     (pop_sum),
      .q_count   (pop_count),
      .q_cross   (pop_cross),
      .q_peak    (pop_peak),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res_data  (res_data)
   );

   // load the output register when it is empty or being drained
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_rms_level       = rsp_data_ff.rms_level;
   assign rsp_zero_cross_rate = rsp_data_ff.zero_cross_rate;
   assign rsp_crest_factor    = rsp_data_ff.crest_factor;
   assign rsp_peak_magnitude  = rsp_data_ff.peak_magnitude;
   assign rsp_frame_samples   = rsp_data_ff.frame_samples;

endmodule

// ===== tb/sv/tb_frame_rms_zcr_crest_top.sv =====
module tb_frame_rms_zcr_crest_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_LIMIT = 4096;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 400;
   localparam int SETTLE_CYCLES = 300;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   logic signed [frzc_pkg::SAMPLE_W-1:0]   req_sample = '0;
   logic                                   req_last_sample = 1'b0;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   logic [frzc_pkg::RMS_W-1:0]             rsp_rms_level;
   logic [frzc_pkg::ZCR_W-1:0]             rsp_zero_cross_rate;
   logic [frzc_pkg::CREST_W-1:0]           rsp_crest_factor;
   logic [frzc_pkg::PEAK_W-1:0]            rsp_peak_magnitude;
   logic [frzc_pkg::FRAME_W-1:0]           rsp_frame_samples;

   int idle_pct = 0;
   int stall_pct = 0;
   int samples_sent = 0;
   int cycles = 0;

   // frame statistics predictor and queue of pending frame results
   class frame_stats_board;
      logic [42:0]                  square_sum;
      logic [frzc_pkg::FRAME_W-1:0] sample_count;
      logic [11:0]                  crossing_count;
      logic [frzc_pkg::MAG_W-1:0]   peak_abs;
      logic                         previous_negative;
      frzc_pkg::result_type         pending[$];
      int                           errors;

      function new();
         errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         square_sum = '0;
         sample_count = '0;
         crossing_count = '0;
         peak_abs = '0;
         previous_negative = 1'b0;
      endfunction

      function logic [frzc_pkg::RMS_W-1:0] floor_root(longint unsigned v);
         longint unsigned r;
         longint unsigned t;
         r = 0;
         for (int b = 16; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
         end
         return r[frzc_pkg::RMS_W-1:0];
      endfunction

      function void note_request(logic signed [frzc_pkg::SAMPLE_W-1:0] s, logic last);
         logic [frzc_pkg::MAG_W-1:0] mag;
         logic                       neg;
         longint unsigned            n;
         longint unsigned            rms;
         longint unsigned            crest;
         frzc_pkg::result_type       res;
         neg = s[frzc_pkg::SAMPLE_W-1];
         mag = neg ? frzc_pkg::MAG_W'(-s) : frzc_pkg::MAG_W'(s);
         square_sum += 43'(mag) * 43'(mag);
         if (mag > peak_abs) peak_abs = mag;
         if (sample_count != 0 && neg != previous_negative) crossing_count++;
         previous_negative = neg;
         sample_count++;
         if (!last && sample_count < FRAME_LIMIT) return;
         n = sample_count;
         rms = floor_root(longint'(square_sum) / n);
         res.rms_level = frzc_pkg::RMS_W'(rms);
         res.zero_cross_rate = (n < 2) ? '0 :
            frzc_pkg::ZCR_W'((longint'(crossing_count) << frzc_pkg::ZCR_FRAC)
                             / (n - 1));
         if (rms == 0) begin
            crest = 0;
         end else begin
            crest = (longint'(peak_abs) << frzc_pkg::CREST_FRAC) / rms;
            if (crest > 65535) crest = 65535;
         end
         res.crest_factor = frzc_pkg::CREST_W'(crest);
         res.peak_magnitude = peak_abs;
         res.frame_samples = frzc_pkg::FRAME_W'(n);
         pending.push_back(res);
         clear_frame();
      endfunction

      task report(string msg);
         $display("%0t mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(frzc_pkg::result_type got);
         frzc_pkg::result_type want;
         if (pending.size() == 0) begin
            report($sformatf("frame result with no frame outstanding (rms %0d, n %0d)",
                             got.rms_level, got.frame_samples));
            return;
         end
         want = pending.pop_front();
         if (got.rms_level !== want.rms_level)
            report($sformatf("rms_level %0d, want %0d", got.rms_level, want.rms_level));
         if (got.zero_cross_rate !== want.zero_cross_rate)
            report($sformatf("zero_cross_rate %0d, want %0d",
                             got.zero_cross_rate, want.zero_cross_rate));
         if (got.crest_factor !== want.crest_factor)
            report($sformatf("crest_factor %0d, want %0d",
                             got.crest_factor, want.crest_factor));
         if (got.peak_magnitude !== want.peak_magnitude)
            report($sformatf("peak_magnitude %0d, want %0d",
                             got.peak_magnitude, want.peak_magnitude));
         if (got.frame_samples !== want.frame_samples)
            report($sformatf("frame_samples %0d, want %0d",
                             got.frame_samples, want.frame_samples));
      endtask
   endclass

   frame_stats_board board = new();

   frame_rms_zcr_crest_top #(.MAX_FRAME(FRAME_LIMIT)) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample          (req_sample),
      .req_last_sample     (req_last_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_rms_level       (rsp_rms_level),
      .rsp_zero_cross_rate (rsp_zero_cross_rate),
      .rsp_crest_factor    (rsp_crest_factor),
      .rsp_peak_magnitude  (rsp_peak_magnitude),
      .rsp_frame_samples   (rsp_frame_samples)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_frame_rms_zcr_crest_top: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(frzc_pkg::result_type'{rsp_rms_level, rsp_zero_cross_rate,
                                                   rsp_crest_factor, rsp_peak_magnitude,
                                                   rsp_frame_samples});
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_sample(logic signed [frzc_pkg::SAMPLE_W-1:0] s, logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      req_last_sample <= last;
      do @(posedge clock); while (!(req_valid && !req_stall));
      board.note_request(s, last);
      samples_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_frame();
      int                                   len;
      int                                   style;
      int                                   pick;
      logic signed [frzc_pkg::SAMPLE_W-1:0] s;
      pick = $urandom_range(9);
      if (pick < 6) len = $urandom_range(16, 1);
      else if (pick < 9) len = $urandom_range(64, 17);
      else len = $urandom_range(300, 65);
      style = $urandom_range(3);
      for (int i = 0; i < len; i++) begin
         case (style)
            0: s = frzc_pkg::SAMPLE_W'($urandom);
            1: s = frzc_pkg::SAMPLE_W'(int'($urandom_range(6)) - 3);
            2: begin
               // alternating sign drives the crossing count up
               s = frzc_pkg::SAMPLE_W'($urandom_range(32767));
               if (i % 2 == 1) s = -s - frzc_pkg::SAMPLE_W'($urandom_range(1));
            end
            default: begin
               case ($urandom_range(4))
                  0: s = 16'sh8000;
                  1: s = 16'sh7fff;
                  2: s = 16'sh0000;
                  3: s = -16'sd1;
                  default: s = 16'sd1;
               endcase
            end
         endcase
         send_sample(s, i == len - 1);
      end
   endtask

   task automatic run_phase(int idle, int stall);
      int target;
      idle_pct = idle;
      stall_pct = stall;
      target = samples_sent + PHASE_ITEMS;
      while (samples_sent < target) send_random_frame();
      drain_results();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // one-sample frames at the extremes
      send_sample(16'sh7fff, 1'b1);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh0000, 1'b1);
      send_sample(-16'sd1, 1'b1);
      // silent frame
      send_sample(16'sh0000, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(16'sh0000, 1'b1);
      // mean square below one step, rms rounds to zero
      send_sample(16'sd1, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(16'sh0000, 1'b1);
      // full-scale alternation, every neighbor pair crosses
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh8000, 1'b1);
      // zero counts as non-negative
      send_sample(16'sh0000, 1'b0);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sh0000, 1'b1);
      drain_results();

      run_phase(0, 0);
      run_phase(80, 0);
      run_phase(0, 80);
      run_phase(10, 10);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.pending.size() != 0)
         board.report($sformatf("%0d frame results never arrived", board.pending.size()));
      if (board.errors == 0)
         $display("tb_frame_rms_zcr_crest_top: done, clean");
      else
         $display("tb_frame_rms_zcr_crest_top: done, errors");
      $finish;
   end

endmodule
